### design/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus read-input-registers client package
// Shared constants, codes and types for the request builder, response parser
// and result emitter.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  // Frame limits.
  localparam int MAX_FRAME_BYTES = 260;
  localparam int MAX_REGISTERS   = 125;
  localparam int REQ_BYTES       = 12;

  // Fixed request contents.
  localparam logic [15:0] PROTOCOL_ID   = 16'h0000;
  localparam logic [15:0] REQ_LENGTH    = 16'h0006;
  localparam logic [7:0]  FC_READ_INPUT = 8'h04;
  localparam logic [7:0]  EXC_MASK      = 8'h80;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Frame status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXCEPTION = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  // Parser modes.
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_BODY   = 2'd1;
  localparam logic [1:0] MODE_DRAIN  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UNIT_ID       = 2'd0;
  localparam logic [1:0] CFG_START_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_REG_COUNT     = 2'd2;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0]  unit_id;
    logic [15:0] start_address;
    logic [7:0]  register_count;
  } cfg_t;

  // Everything the emitter needs to deliver the results of one input item.
  typedef struct packed {
    logic        is_req;
    logic [15:0] tid;
    logic [7:0]  unit_id;
    logic [15:0] start_address;
    logic [7:0]  register_count;
    logic        has_reg;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic        has_status;
    logic [1:0]  status;
  } job_t;

  // A register count is usable only in the range 1 to MAX_REGISTERS.
  function automatic logic count_ok(input logic [7:0] cnt);
    return (cnt != 8'd0) && (cnt <= 8'(MAX_REGISTERS));
  endfunction

endpackage

### design/mbrc_parser.sv
// ----------------------------------------------------------------------------
// Modbus client parser
// Holds the transaction counter and the response frame state, and turns one
// accepted input item into a job description for the emitter.
// ----------------------------------------------------------------------------
module mbrc_parser (
  input  logic           clk,
  input  logic           rst,
  input  mbrc_pkg::cfg_t cfg,
  input  logic           take,
  input  logic           action,
  input  logic [7:0]     rx_byte,
  output mbrc_pkg::job_t job,
  output logic           job_any
);
  import mbrc_pkg::*;

  logic [15:0] tid, tid_next;
  logic [8:0]  pos, pos_next;
  logic [15:0] rid, rid_next;
  logic [15:0] len, len_next;
  logic [7:0]  func, func_next;
  logic [7:0]  cnt, cnt_next;
  logic [7:0]  pend, pend_next;
  logic [1:0]  mode, mode_next;

  logic [15:0] len_hdr;
  logic [8:0]  off;
  logic [7:0]  idx;
  logic        count_match;
  logic        frame_end;
  logic        length_match;

  assign len_hdr      = {len[15:8], rx_byte};
  assign off          = pos - 9'd9;
  assign idx          = off[8:1];
  assign count_match  = ({1'b0, cnt} == {cfg.register_count, 1'b0});
  assign frame_end    = ({8'd0, pos} >= ({1'b0, len} + 17'd5));
  assign length_match = ({1'b0, len} == (17'd3 + {8'd0, cfg.register_count, 1'b0}));

  // Next state and job for the item at the input.
  always_comb begin
    tid_next  = tid;
    pos_next  = pos;
    rid_next  = rid;
    len_next  = len;
    func_next = func;
    cnt_next  = cnt;
    pend_next = pend;
    mode_next = mode;
    job       = '0;
    job_any   = 1'b0;

    if (!action) begin
      // Start of a new request: the parser always falls back to the header.
      pos_next  = 9'd0;
      mode_next = MODE_HEADER;
      job_any   = 1'b1;
      if (!count_ok(cfg.register_count)) begin
        job.has_status = 1'b1;
        job.status     = ST_INVALID;
      end else begin
        tid_next           = tid + 16'd1;
        job.is_req         = 1'b1;
        job.tid            = tid + 16'd1;
        job.unit_id        = cfg.unit_id;
        job.start_address  = cfg.start_address;
        job.register_count = cfg.register_count;
      end
    end else if (mode == MODE_HEADER) begin
      pos_next = pos + 9'd1;
      if (pos == 9'd0) begin
        rid_next = {rx_byte, 8'h00};
      end else if (pos == 9'd1) begin
        rid_next = {rid[15:8], rx_byte};
      end else if (pos == 9'd4) begin
        len_next = {rx_byte, 8'h00};
      end else if (pos == 9'd5) begin
        len_next  = len_hdr;
        func_next = 8'h00;
        cnt_next  = 8'h00;
        if (rid != tid) begin
          // Foreign transaction: drain it if its length is sane.
          if (len_hdr == 16'd0 || len_hdr > 16'(MAX_FRAME_BYTES)) begin
            job_any        = 1'b1;
            job.has_status = 1'b1;
            job.status     = ST_INVALID;
            pos_next       = 9'd0;
          end else begin
            mode_next = MODE_DRAIN;
          end
        end else if (len_hdr == 16'd0 || len_hdr > 16'(MAX_FRAME_BYTES - 6)) begin
          job_any        = 1'b1;
          job.has_status = 1'b1;
          job.status     = ST_INVALID;
          pos_next       = 9'd0;
        end else begin
          mode_next = MODE_BODY;
        end
      end
    end else begin
      // Body bytes: function, byte count, then register pairs.
      if (mode == MODE_BODY) begin
        if (pos == 9'd7) begin
          func_next = rx_byte;
        end else if (pos == 9'd8) begin
          cnt_next = rx_byte;
        end else if (pos >= 9'd9) begin
          if (!off[0]) begin
            pend_next = rx_byte;
          end else if (count_ok(cfg.register_count) && ((func & EXC_MASK) == 8'h00) &&
                       count_match && (idx < cfg.register_count)) begin
            job_any       = 1'b1;
            job.has_reg   = 1'b1;
            job.reg_value = {pend, rx_byte};
            job.reg_index = idx[6:0];
          end
        end
      end
      pos_next = pos + 9'd1;
      // The last byte of the frame closes it with one status.
      if (frame_end) begin
        job_any        = 1'b1;
        job.has_status = 1'b1;
        pos_next       = 9'd0;
        mode_next      = MODE_HEADER;
        priority if (mode == MODE_DRAIN || len < 16'd2) begin
          job.status = ST_INVALID;
        end else if ((func_next & EXC_MASK) != 8'h00) begin
          job.status = ST_EXCEPTION;
        end else if (!count_ok(cfg.register_count) ||
                     ({1'b0, cnt_next} != {cfg.register_count, 1'b0}) || !length_match) begin
          job.status = ST_INVALID;
        end else begin
          job.status = ST_OK;
        end
      end
    end
  end

  // State registers, updated on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      tid  <= '0;
      pos  <= '0;
      rid  <= '0;
      len  <= '0;
      func <= '0;
      cnt  <= '0;
      pend <= '0;
      mode <= MODE_HEADER;
    end else if (take) begin
      tid  <= tid_next;
      pos  <= pos_next;
      rid  <= rid_next;
      len  <= len_next;
      func <= func_next;
      cnt  <= cnt_next;
      pend <= pend_next;
      mode <= mode_next;
    end
  end

  // The header is six bytes long.
  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HEADER |-> pos <= 9'd5)
    else $error("header position beyond the six header bytes");

  // A body or drained frame never runs past the longest allowed frame.
  a_body_pos: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_HEADER |-> pos <= 9'(MAX_FRAME_BYTES + 5))
    else $error("frame position beyond the longest frame");

  // The counter only moves on a start with a usable count.
  a_tid_step: assert property (@(posedge clk) disable iff (rst)
    take && (action || !count_ok(cfg.register_count)) |=> $stable(tid))
    else $error("transaction counter moved without a request");

endmodule

### design/mbrc_emitter.sv
// ----------------------------------------------------------------------------
// Modbus client result emitter
// Holds one item's job; delivers one result per cycle while out_ready is set:
// twelve request bytes, or a register value and/or a frame status.
// ----------------------------------------------------------------------------
module mbrc_emitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mbrc_pkg::job_t job,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [7:0]     tx_byte,
  output logic [15:0]    register_value,
  output logic [6:0]     register_index,
  output logic [1:0]     status,
  output logic           last
);
  import mbrc_pkg::*;

  job_t       cur;
  logic       busy;
  logic [3:0] step;
  logic       fin;

  // Format the current result from the held job.
  always_comb begin
    kind           = KIND_STATUS;
    tx_byte        = 8'h00;
    register_value = 16'h0000;
    register_index = 7'd0;
    status         = 2'd0;
    last           = 1'b1;
    if (cur.is_req) begin
      kind = KIND_TX;
      last = (step == 4'(REQ_BYTES - 1));
      unique case (step)
        4'd0:    tx_byte = cur.tid[15:8];
        4'd1:    tx_byte = cur.tid[7:0];
        4'd2:    tx_byte = PROTOCOL_ID[15:8];
        4'd3:    tx_byte = PROTOCOL_ID[7:0];
        4'd4:    tx_byte = REQ_LENGTH[15:8];
        4'd5:    tx_byte = REQ_LENGTH[7:0];
        4'd6:    tx_byte = cur.unit_id;
        4'd7:    tx_byte = FC_READ_INPUT;
        4'd8:    tx_byte = cur.start_address[15:8];
        4'd9:    tx_byte = cur.start_address[7:0];
        4'd10:   tx_byte = 8'h00;
        4'd11:   tx_byte = cur.register_count;
        default: tx_byte = 8'h00;
      endcase
    end else if (cur.has_reg && step == 4'd0) begin
      kind           = KIND_REG;
      register_value = cur.reg_value;
      register_index = cur.reg_index;
      last           = !cur.has_status;
    end else begin
      status = cur.status;
    end
  end

  assign out_valid = busy;
  assign fin       = busy && out_ready && last;
  assign free      = !busy || fin;

  // Control: a new job replaces the finished one in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (load) begin
      busy <= 1'b1;
      step <= 4'd0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      step <= step + 4'd1;
    end
  end

  // Job payload.
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job;
    end
  end

  // A request job never steps past its twelfth byte.
  a_req_step: assert property (@(posedge clk) disable iff (rst)
    busy && cur.is_req |-> step < 4'(REQ_BYTES))
    else $error("request byte index out of range");

  // A response job has at most two results and at least one.
  a_rsp_step: assert property (@(posedge clk) disable iff (rst)
    busy && !cur.is_req |-> step <= 4'd1 && (cur.has_reg || cur.has_status))
    else $error("response job in an impossible step");

  // After its final transfer the emitter is empty unless a new job came in.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    fin && !load |=> !busy)
    else $error("emitter still busy after its final transfer");

  // Register indexes stay inside the largest response.
  a_reg_index: assert property (@(posedge clk) disable iff (rst)
    busy && kind == KIND_REG |-> register_index < 7'(MAX_REGISTERS))
    else $error("register index out of range");

endmodule

### design/modbus_read_input_regs_client.sv
// ----------------------------------------------------------------------------
// Modbus TCP read-input-registers client
// Builds function 0x04 requests and parses response bytes into register
// values and one status per frame.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one item per transfer: action 0
// starts a request, action 1 feeds one received response byte in rx_byte.
// The output channel (out_valid/out_ready) delivers results: request bytes
// (kind 0), register values (kind 1) and frame statuses (kind 2), with last
// set on the final result of each input item.
// The first result of an input transfer is registered and offered in the
// cycle after it. A response byte with at most one result is taken every
// cycle while out_ready is high; a start or a byte with a register and a
// status holds the input until its last result goes, as the single result
// register delivers one result per cycle. A byte that yields no result also
// waits while earlier results are held, since the input is ready only when
// the result register is empty or its last result is being transferred.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the unit id,
// start address and register count; write it only while the block is idle.
// Reset clears the transaction counter and the parser and restores the
// configuration defaults (unit 1, address 0, count 8).
// When the receiver stalls, the held result stays and the input is taken
// again in the cycle its last result is transferred.
// ----------------------------------------------------------------------------
module modbus_read_input_regs_client (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] register_value,
  output logic [6:0]  register_index,
  output logic [1:0]  status,
  output logic        last
);
  import mbrc_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_any;
  logic take;
  logic free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_id        <= 8'd1;
      cfg.start_address  <= 16'd0;
      cfg.register_count <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_ID:       cfg.unit_id        <= cfg_data[7:0];
        CFG_START_ADDRESS: cfg.start_address  <= cfg_data;
        CFG_REG_COUNT:     cfg.register_count <= cfg_data[7:0];
        default:           ;
      endcase
    end
  end

  // Input transfer.
  assign in_ready = free;
  assign take     = in_valid && free;

  mbrc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .take    (take),
    .action  (action),
    .rx_byte (rx_byte),
    .job     (job),
    .job_any (job_any)
  );

  mbrc_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .load           (take && job_any),
    .job            (job),
    .free           (free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .register_value (register_value),
    .register_index (register_index),
    .status         (status),
    .last           (last)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the Modbus read-input-registers client
// Sends request starts and response byte streams through the input channel.
// An in-bench model of the client predicts every request byte, register
// value and frame status, and each output transfer is checked against it.
// ----------------------------------------------------------------------------
module testbench;
  import mbrc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 16;
  localparam int NO_CUT      = 65536;
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef enum {
    FRAME_ANY, FRAME_GOOD, FRAME_EXCEPTION, FRAME_OTHER_ID, FRAME_BAD_LENGTH,
    FRAME_WRONG_LENGTH, FRAME_WRONG_COUNT, FRAME_OTHER_FUNCTION, FRAME_CUT, FRAME_NOISE
  } frame_variant_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] register_value;
  logic [6:0]  register_index;
  logic [1:0]  status;
  logic        last;

  // Items waiting for the driver and results waiting for the monitor.
  rx_item_t pending_items [$];
  result_t  expected_results [$];
  result_t  oldest_expected;

  // Pacing and bookkeeping.
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatch_count;
  int accepted_count;
  int reg_result_count;
  int status_result_count;
  int setting_count;
  bit in_fire;

  // Stimulus generator's view of the counter and the configured count.
  logic [15:0] gen_tid;
  logic [7:0]  gen_count;
  bit          need_start;

  // Client model: configuration copy and parser state.
  logic [7:0]  conf_unit_id;
  logic [15:0] conf_start_address;
  logic [7:0]  conf_register_count;
  logic [15:0] trans_id;
  logic [8:0]  frame_pos;
  logic [15:0] rx_id;
  logic [15:0] frame_len;
  logic [7:0]  fn_byte;
  logic [7:0]  count_field;
  logic [7:0]  high_byte;
  logic [1:0]  parse_mode;

  modbus_read_input_regs_client i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .register_value(register_value),
    .register_index(register_index),
    .status        (status),
    .last          (last)
  );

  always #5 clk = ~clk;

  function automatic result_t make_result(input logic [1:0] k, input logic [7:0] tx,
                                          input logic [15:0] val, input logic [6:0] idx,
                                          input logic [1:0] st);
    result_t r;
    r.kind      = k;
    r.tx_byte   = tx;
    r.reg_value = val;
    r.reg_index = idx;
    r.status    = st;
    r.last      = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted item and advance the model state.
  task automatic predict_transfer(input logic act, input logic [7:0] b);
    result_t     batch [12];
    int          n;
    int unsigned pos;
    int unsigned count_twice;
    logic        count_valid;
    logic [95:0] request;
    logic [1:0]  frame_status;
    n = 0;
    count_valid = (conf_register_count >= 8'd1) &&
                  (conf_register_count <= 8'(MAX_REGISTERS));
    count_twice = 2 * conf_register_count;
    if (act == ACT_START) begin
      // A start always resets the parser, even when the count is unusable.
      frame_pos  = '0;
      parse_mode = MODE_HEADER;
      if (!count_valid) begin
        batch[n] = make_result(KIND_STATUS, 8'h00, 16'h0000, 7'd0, ST_INVALID);
        n++;
      end else begin
        trans_id = trans_id + 16'd1;
        request = {trans_id, PROTOCOL_ID, REQ_LENGTH, conf_unit_id, FC_READ_INPUT,
                   conf_start_address, 8'h00, conf_register_count};
        for (int i = 0; i < REQ_BYTES; i++) begin
          batch[n] = make_result(KIND_TX, request[95 - 8 * i -: 8], 16'h0000, 7'd0, ST_OK);
          n++;
        end
      end
    end else begin
      pos = frame_pos;
      if (parse_mode == MODE_HEADER) begin
        // Collect the transaction id and length, then decide on the sixth byte.
        case (pos)
          0: rx_id = {b, 8'h00};
          1: rx_id[7:0] = b;
          4: frame_len = {b, 8'h00};
          5: frame_len[7:0] = b;
          default: ;
        endcase
        frame_pos = frame_pos + 9'd1;
        if (pos == 5) begin
          fn_byte     = '0;
          count_field = '0;
          if (rx_id != trans_id) begin
            if (frame_len == 0 || frame_len > MAX_FRAME_BYTES) begin
              batch[n] = make_result(KIND_STATUS, 8'h00, 16'h0000, 7'd0, ST_INVALID);
              n++;
              frame_pos  = '0;
              parse_mode = MODE_HEADER;
            end else begin
              parse_mode = MODE_DRAIN;
            end
          end else if (frame_len == 0 || frame_len > MAX_FRAME_BYTES - 6) begin
            batch[n] = make_result(KIND_STATUS, 8'h00, 16'h0000, 7'd0, ST_INVALID);
            n++;
            frame_pos  = '0;
            parse_mode = MODE_HEADER;
          end else begin
            parse_mode = MODE_BODY;
          end
        end
      end else begin
        // Body bytes: function, byte count, then big-endian register pairs.
        if (parse_mode == MODE_BODY) begin
          if (pos == 7) begin
            fn_byte = b;
          end else if (pos == 8) begin
            count_field = b;
          end else if (pos >= 9) begin
            if (((pos - 9) % 2) == 0) begin
              high_byte = b;
            end else if (count_valid && !fn_byte[7] && count_field == count_twice &&
                         (pos - 9) / 2 < conf_register_count) begin
              batch[n] = make_result(KIND_REG, 8'h00, {high_byte, b}, 7'((pos - 9) / 2),
                                     ST_OK);
              n++;
            end
          end
        end
        frame_pos = frame_pos + 9'd1;
        // The byte at the end of the announced length closes the frame.
        if (pos >= 5 + frame_len) begin
          if (parse_mode == MODE_DRAIN || frame_len < 2) begin
            frame_status = ST_INVALID;
          end else if (fn_byte[7]) begin
            frame_status = ST_EXCEPTION;
          end else if (!count_valid || count_field != count_twice ||
                       frame_len != 3 + count_twice) begin
            frame_status = ST_INVALID;
          end else begin
            frame_status = ST_OK;
          end
          batch[n] = make_result(KIND_STATUS, 8'h00, 16'h0000, 7'd0, frame_status);
          n++;
          frame_pos  = '0;
          parse_mode = MODE_HEADER;
        end
      end
    end
    if (n > 0) begin
      batch[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_results.push_back(batch[i]);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Monitor: track configuration writes, predict on each input transfer and
  // check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (rst) begin
      conf_unit_id        = 8'd1;
      conf_start_address  = 16'h0000;
      conf_register_count = 8'd8;
      trans_id            = '0;
      frame_pos           = '0;
      rx_id               = '0;
      frame_len           = '0;
      fn_byte             = '0;
      count_field         = '0;
      high_byte           = '0;
      parse_mode          = MODE_HEADER;
    end else begin
      if (out_valid && out_ready) begin
        if (kind == KIND_REG) begin
          reg_result_count++;
        end else if (kind == KIND_STATUS) begin
          status_result_count++;
        end
        if (expected_results.size() == 0) begin
          $error("Result transfer with nothing expected: kind %0d", kind);
          mismatch_count++;
        end else begin
          oldest_expected = expected_results.pop_front();
          check_field("kind", oldest_expected.kind, kind);
          check_field("tx_byte", oldest_expected.tx_byte, tx_byte);
          check_field("register_value", oldest_expected.reg_value, register_value);
          check_field("register_index", oldest_expected.reg_index, register_index);
          check_field("status", oldest_expected.status, status);
          check_field("last", oldest_expected.last, last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNIT_ID:       conf_unit_id = cfg_data[7:0];
          CFG_START_ADDRESS: conf_start_address = cfg_data;
          CFG_REG_COUNT:     conf_register_count = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        accepted_count++;
        predict_transfer(action, rx_byte);
      end
    end
  end

  // Driver: present the next pending item after a transfer or an idle
  // cycle, and pace the receiver.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          {action, rx_byte} <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_items.push_back({ACT_BYTE, b});
  endtask

  // Push n bytes of a right-aligned byte string, first byte first.
  task automatic queue_raw(input logic [127:0] bytes, input int n);
    for (int i = 0; i < n; i++) begin
      queue_byte(bytes[8 * (n - 1 - i) +: 8]);
    end
  endtask

  task automatic queue_start();
    pending_items.push_back({ACT_START, 8'($urandom)});
    if (gen_count >= 8'd1 && gen_count <= 8'(MAX_REGISTERS)) begin
      gen_tid = gen_tid + 16'd1;
    end
  endtask

  // One response frame; the body stops where the client will end the frame
  // early, or after 'limit' body bytes for a cut-off frame.
  task automatic queue_frame(input logic [15:0] id, input logic [15:0] len,
                             input logic [7:0] fn, input logic [7:0] cnt_byte,
                             input int limit);
    logic [15:0] proto;
    int          body;
    proto = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PROTOCOL_ID;
    queue_raw({id, proto, len}, 6);
    if (len == 0 || len > ((id == gen_tid) ? MAX_FRAME_BYTES - 6 : MAX_FRAME_BYTES)) begin
      body = 0;
    end else begin
      body = len;
    end
    if (limit < body) begin
      body = limit;
    end
    for (int i = 0; i < body; i++) begin
      queue_byte((i == 1) ? fn : (i == 2) ? cnt_byte : 8'($urandom));
    end
  endtask

  // A request start (usually) followed by one response of the given flavor.
  task automatic queue_exchange(input frame_variant_t variant);
    int          roll;
    logic [15:0] good_len;
    logic [15:0] len;
    logic [7:0]  good_cnt;
    good_len = 16'(3 + 2 * gen_count);
    good_cnt = 8'(2 * gen_count);
    if (variant == FRAME_ANY) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      variant = FRAME_GOOD;
      else if (roll < 55) variant = FRAME_EXCEPTION;
      else if (roll < 63) variant = FRAME_OTHER_ID;
      else if (roll < 69) variant = FRAME_BAD_LENGTH;
      else if (roll < 77) variant = FRAME_WRONG_LENGTH;
      else if (roll < 84) variant = FRAME_WRONG_COUNT;
      else if (roll < 90) variant = FRAME_OTHER_FUNCTION;
      else if (roll < 95) variant = FRAME_CUT;
      else                variant = FRAME_NOISE;
    end
    // Now and then a response arrives with no new request in front of it.
    if (need_start || $urandom_range(0, 9) != 0) begin
      queue_start();
    end
    need_start = 0;
    case (variant)
      FRAME_GOOD: begin
        queue_frame(gen_tid, good_len, FC_READ_INPUT, good_cnt, NO_CUT);
      end
      FRAME_EXCEPTION: begin
        queue_frame(gen_tid, 16'($urandom_range(2, 6)), EXC_MASK | 8'($urandom_range(0, 127)),
                    8'($urandom), NO_CUT);
      end
      FRAME_OTHER_ID: begin
        if ($urandom_range(0, 9) == 0) begin
          len = ($urandom_range(0, 1) == 0) ? 16'd0
                : 16'($urandom_range(MAX_FRAME_BYTES + 1, 65535));
        end else begin
          len = 16'($urandom_range(1, 24));
        end
        queue_frame(gen_tid + 16'($urandom_range(1, 65535)), len, 8'($urandom), 8'($urandom),
                    NO_CUT);
      end
      FRAME_BAD_LENGTH: begin
        len = ($urandom_range(0, 3) == 0) ? 16'd0
              : 16'($urandom_range(MAX_FRAME_BYTES - 5, 65535));
        queue_frame(gen_tid, len, FC_READ_INPUT, good_cnt, NO_CUT);
      end
      FRAME_WRONG_LENGTH: begin
        len = 16'($urandom_range(1, int'(good_len) + 4));
        if (len == good_len) begin
          len = len + 16'd1;
        end
        queue_frame(gen_tid, len, FC_READ_INPUT, good_cnt, NO_CUT);
      end
      FRAME_WRONG_COUNT: begin
        queue_frame(gen_tid, good_len, FC_READ_INPUT, good_cnt ^ (8'd1 << $urandom_range(0, 7)),
                    NO_CUT);
      end
      FRAME_OTHER_FUNCTION: begin
        queue_frame(gen_tid, good_len, 8'($urandom_range(0, 127)), good_cnt, NO_CUT);
      end
      FRAME_CUT: begin
        // The next start lands in the middle of this frame.
        queue_frame(gen_tid, good_len, FC_READ_INPUT, good_cnt,
                    $urandom_range(0, int'(good_len) - 1));
        need_start = 1;
      end
      default: begin
        repeat ($urandom_range(1, 12)) queue_byte(8'($urandom));
        need_start = 1;
      end
    endcase
  endtask

  // Write all three registers while nothing is in flight.
  task automatic set_config(input logic [7:0] unit, input logic [15:0] addr,
                            input logic [7:0] cnt);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNIT_ID;
    cfg_data  <= {8'($urandom), unit};
    @(negedge clk);
    cfg_index <= CFG_START_ADDRESS;
    cfg_data  <= addr;
    @(negedge clk);
    cfg_index <= CFG_REG_COUNT;
    cfg_data  <= {8'($urandom), cnt};
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_count = cnt;
    setting_count++;
    @(posedge clk);
  endtask

  // Wait until every item has been transferred and every result checked,
  // then let the block finish bytes that emit nothing.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_UNIT_ID;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_START;
    rx_byte   = '0;
    out_ready = 1'b0;
    gen_tid   = '0;
    gen_count = 8'd8;
    need_start = 1;
    send_idle_pct = 15;
    recv_idle_pct = 60;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a good frame with all-ones data, an exception reply with a
    // nonzero protocol field, an oversized length, and a start while the
    // register count is zero.
    set_config(8'd1, 16'h0000, 8'd1);
    queue_start();
    queue_raw({16'h0001, PROTOCOL_ID, 16'h0005, 8'h01, FC_READ_INPUT, 8'h02, 16'hFFFF}, 11);
    queue_raw({16'h0001, 16'hFFFF, 16'h0002, 8'h00, EXC_MASK | FC_READ_INPUT}, 8);
    queue_raw({16'h0001, PROTOCOL_ID, 16'hFFFF}, 6);
    wait_idle();
    set_config(8'd1, 16'h0000, 8'd0);
    queue_start();

    // Random exchanges over several settings and three pacing modes.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 2) begin
        send_idle_pct = 60;
        recv_idle_pct = 15;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_config(8'h00, 16'h0000, 8'd1);
        1: set_config(8'hFF, 16'hFFFF, 8'd2);
        2: set_config(8'($urandom), 16'($urandom), 8'($urandom_range(1, 4)));
        3: set_config(8'($urandom), 16'($urandom), 8'd0);
        4: set_config(8'($urandom), 16'($urandom), 8'(MAX_REGISTERS + 1));
        default: set_config(8'($urandom), 16'($urandom), 8'hFF);
      endcase
      need_start = 1;
      while (pending_items.size() < PHASE_ITEMS) begin
        queue_exchange(FRAME_ANY);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    $display("Covered %0d input transfers, %0d register values and %0d frame statuses",
             accepted_count, reg_result_count, status_result_count);
    $display("across %0d register settings and three handshake pacing modes.", setting_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
